// File: rtl/mjar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Motor jam auto-reverse package
// Field widths, register indexes and register reset values shared by the
// channel interfaces and the controller.
// ----------------------------------------------------------------------------
package mjar_pkg;

    localparam int unsigned LevelWidth    = 10;
    localparam int unsigned IntervalWidth = 16;
    localparam int unsigned MsWidth       = 20;
    localparam int unsigned CountWidth    = 8;
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 20;

    localparam logic [CfgIndexWidth-1:0] REG_CUT_THRESHOLD    = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_READ_INTERVAL_MS = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_STUCK_MS         = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_WARNING_MS       = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_TURN_DELAY_MS    = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_STEPS_PER_REV    = 3'd5;

    localparam logic [LevelWidth-1:0]    CUT_THRESHOLD_RST    = 10'd512;
    localparam logic [IntervalWidth-1:0] READ_INTERVAL_RST    = 16'd10;
    localparam logic [MsWidth-1:0]       STUCK_MS_RST         = 20'd5000;
    localparam logic [MsWidth-1:0]       WARNING_MS_RST       = 20'd30000;
    localparam logic [MsWidth-1:0]       TURN_DELAY_MS_RST    = 20'd2000;
    localparam logic [CountWidth-1:0]    STEPS_PER_REV_RST    = 8'd20;

    localparam logic [MsWidth-1:0]       EDGE_MAX             = '1;
    localparam logic [CountWidth-1:0]    REV_MAX              = '1;

endpackage : mjar_pkg
`default_nettype wire

// File: rtl/mjar_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Motor jam auto-reverse tick channel
// Valid/ready channel carrying one millisecond tick: run switch and sensor.
// ----------------------------------------------------------------------------
interface mjar_in_if
    import mjar_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  run_request;
    logic [LevelWidth-1:0] sensor_level;

    modport source (output valid, output run_request, output sensor_level, input ready);
    modport sink   (input valid, input run_request, input sensor_level, output ready);
endinterface : mjar_in_if
`default_nettype wire

// File: rtl/mjar_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Motor jam auto-reverse result channel
// Valid/ready channel carrying the drive commands and counters after a tick.
// ----------------------------------------------------------------------------
interface mjar_out_if
    import mjar_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  forward_drive;
    logic                  backward_drive;
    logic                  warning_lamp;
    logic [CountWidth-1:0] step_count;
    logic [CountWidth-1:0] revolution_count;
    logic                  clearing_jam;

    modport source (
        output valid, output forward_drive, output backward_drive, output warning_lamp,
        output step_count, output revolution_count, output clearing_jam, input ready
    );
    modport sink (
        input valid, input forward_drive, input backward_drive, input warning_lamp,
        input step_count, input revolution_count, input clearing_jam, output ready
    );
endinterface : mjar_out_if
`default_nettype wire

// File: rtl/motor_jam_auto_reverse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Motor jam auto-reverse controller
// Counts encoder steps and revolutions per tick, reverses after a jam and
// latches a no-motion warning.
//
//   Channel  Modport  Carries
//   sample   sink     run_request, sensor_level (one tick per transaction)
//   result   source   drives, warning lamp, counters, clearing flag
//   cfg_*    write    register index and data, no read-back
//
// One tick is taken per cycle unless the result is stalled; the whole state
// update is one pass of logic into the state and result registers.
// A tick is accepted whenever the result register is empty or being emptied,
// so a stalled result only holds off the next transaction.
// Reset is asynchronous and active low and loads the register defaults.
// ----------------------------------------------------------------------------
module motor_jam_auto_reverse
    import mjar_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    mjar_in_if.sink                       sample,
    mjar_out_if.source                    result,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data
);

    logic [LevelWidth-1:0]    cut_threshold_reg;
    logic [IntervalWidth-1:0] read_interval_reg;
    logic [MsWidth-1:0]       stuck_ms_reg;
    logic [MsWidth-1:0]       warning_ms_reg;
    logic [MsWidth-1:0]       turn_delay_reg;
    logic [CountWidth-1:0]    steps_per_rev_reg;

    logic                     started_reg, started_next;
    logic                     backward_reg, backward_next;
    logic                     unjamming_reg, unjamming_next;
    logic                     warning_reg, warning_next;
    logic                     last_cut_reg, last_cut_next;
    logic [CountWidth-1:0]    steps_reg, steps_next;
    logic [CountWidth-1:0]    revs_reg, revs_next;
    logic [MsWidth-1:0]       since_edge_reg, since_edge_next;
    logic [IntervalWidth-1:0] since_read_reg, since_read_next;
    logic [MsWidth-1:0]       turn_wait_reg, turn_wait_next;

    logic                     out_valid_reg;
    logic                     fwd_reg, bwd_reg, lamp_reg, clearing_reg;
    logic [CountWidth-1:0]    step_out_reg, rev_out_reg;

    logic                     accept;
    logic                     cut;
    logic                     driving;
    logic [CountWidth-1:0]    step_inc;
    logic [MsWidth-1:0]       edge_inc;

    assign sample.ready = !out_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;
    assign cut          = sample.sensor_level < cut_threshold_reg;
    assign step_inc     = steps_reg + CountWidth'(1);
    assign edge_inc     = (since_edge_reg == EDGE_MAX) ? since_edge_reg
                                                        : since_edge_reg + MsWidth'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_threshold_reg <= CUT_THRESHOLD_RST;
            read_interval_reg <= READ_INTERVAL_RST;
            stuck_ms_reg      <= STUCK_MS_RST;
            warning_ms_reg    <= WARNING_MS_RST;
            turn_delay_reg    <= TURN_DELAY_MS_RST;
            steps_per_rev_reg <= STEPS_PER_REV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CUT_THRESHOLD:    cut_threshold_reg <= cfg_data[LevelWidth-1:0];
                REG_READ_INTERVAL_MS: read_interval_reg <= cfg_data[IntervalWidth-1:0];
                REG_STUCK_MS:         stuck_ms_reg      <= cfg_data[MsWidth-1:0];
                REG_WARNING_MS:       warning_ms_reg    <= cfg_data[MsWidth-1:0];
                REG_TURN_DELAY_MS:    turn_delay_reg    <= cfg_data[MsWidth-1:0];
                REG_STEPS_PER_REV:    steps_per_rev_reg <= cfg_data[CountWidth-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        started_next    = started_reg;
        backward_next   = backward_reg;
        unjamming_next  = unjamming_reg;
        warning_next    = warning_reg;
        last_cut_next   = last_cut_reg;
        steps_next      = steps_reg;
        revs_next       = revs_reg;
        since_edge_next = since_edge_reg;
        since_read_next = since_read_reg;
        turn_wait_next  = turn_wait_reg;

        if (sample.run_request && !warning_reg)
        begin
            started_next = 1'b1;
            priority if (turn_wait_reg != '0)
            begin
                turn_wait_next = turn_wait_reg - MsWidth'(1);
                if (turn_wait_reg == MsWidth'(1))
                begin
                    backward_next   = !backward_reg;
                    since_edge_next = '0;
                    since_read_next = '0;
                end
            end
            else if (since_edge_reg >= warning_ms_reg)
            begin
                // The warning stops the machine within the same tick.
                warning_next    = 1'b1;
                started_next    = 1'b0;
                since_edge_next = '0;
                since_read_next = '0;
                last_cut_next   = cut;
                steps_next      = '0;
                revs_next       = '0;
                backward_next   = 1'b0;
                unjamming_next  = 1'b0;
                turn_wait_next  = '0;
            end
            else if (since_read_reg < read_interval_reg)
            begin
                since_read_next = since_read_reg + IntervalWidth'(1);
                since_edge_next = edge_inc;
            end
            else
            begin
                since_read_next = '0;
                if ((since_edge_reg >= stuck_ms_reg) ||
                    (unjamming_reg && backward_reg && (revs_reg != '0)))
                begin
                    // Jam reversal or return forward after one backward revolution.
                    unjamming_next = 1'b1;
                    steps_next     = '0;
                    revs_next      = '0;
                    turn_wait_next = turn_delay_reg;
                    if (turn_delay_reg == '0)
                    begin
                        backward_next   = !backward_reg;
                        since_edge_next = '0;
                        since_read_next = '0;
                    end
                end
                else if (cut != last_cut_reg)
                begin
                    last_cut_next   = cut;
                    since_edge_next = '0;
                    if (!cut)
                    begin
                        if (step_inc == steps_per_rev_reg)
                        begin
                            steps_next = '0;
                            if (revs_reg != REV_MAX)
                            begin
                                revs_next = revs_reg + CountWidth'(1);
                            end
                            if (!backward_reg)
                            begin
                                unjamming_next = 1'b0;
                            end
                        end
                        else
                        begin
                            steps_next = step_inc;
                        end
                    end
                end
                else
                begin
                    since_edge_next = edge_inc;
                end
            end
        end
        else
        begin
            since_edge_next = '0;
            since_read_next = '0;
            last_cut_next   = cut;
            if (started_reg)
            begin
                started_next   = 1'b0;
                steps_next     = '0;
                revs_next      = '0;
                backward_next  = 1'b0;
                unjamming_next = 1'b0;
                turn_wait_next = '0;
            end
        end
    end

    assign driving = started_next && !warning_next && (turn_wait_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg    <= 1'b0;
            backward_reg   <= 1'b0;
            unjamming_reg  <= 1'b0;
            warning_reg    <= 1'b0;
            last_cut_reg   <= 1'b0;
            steps_reg      <= '0;
            revs_reg       <= '0;
            since_edge_reg <= '0;
            since_read_reg <= '0;
            turn_wait_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                started_reg    <= started_next;
                backward_reg   <= backward_next;
                unjamming_reg  <= unjamming_next;
                warning_reg    <= warning_next;
                last_cut_reg   <= last_cut_next;
                steps_reg      <= steps_next;
                revs_reg       <= revs_next;
                since_edge_reg <= since_edge_next;
                since_read_reg <= since_read_next;
                turn_wait_reg  <= turn_wait_next;
                out_valid_reg  <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_reg      <= driving && !backward_next;
            bwd_reg      <= driving && backward_next;
            lamp_reg     <= warning_next;
            step_out_reg <= steps_next;
            rev_out_reg  <= revs_next;
            clearing_reg <= unjamming_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.forward_drive    = fwd_reg;
    assign result.backward_drive   = bwd_reg;
    assign result.warning_lamp     = lamp_reg;
    assign result.step_count       = step_out_reg;
    assign result.revolution_count = rev_out_reg;
    assign result.clearing_jam     = clearing_reg;

endmodule : motor_jam_auto_reverse
`default_nettype wire

// File: bench/jam_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor jam auto-reverse checking package
// Holds a cycle-free model of the jam controller. It keeps its own copy of
// the registers and controller state. It works out the drive result of every
// accepted tick transaction and compares the returned results in order.
// ----------------------------------------------------------------------------
package jam_check_pkg;
    import mjar_pkg::*;

    typedef struct packed {
        logic                  forward_drive;
        logic                  backward_drive;
        logic                  warning_lamp;
        logic [CountWidth-1:0] step_count;
        logic [CountWidth-1:0] revolution_count;
        logic                  clearing_jam;
    } drive_result_t;

    typedef struct packed {
        logic [LevelWidth-1:0]    cut_level;
        logic [IntervalWidth-1:0] read_gap_ms;
        logic [MsWidth-1:0]       jam_ms;
        logic [MsWidth-1:0]       alarm_ms;
        logic [MsWidth-1:0]       pause_ms;
        logic [CountWidth-1:0]    rev_steps;
    } jam_settings_t;

    class drive_scoreboard;
        jam_settings_t            regs;
        bit                       running;
        bit                       reversing;
        bit                       unjamming;
        bit                       alarm;
        bit                       was_cut;
        logic [CountWidth-1:0]    step_cnt;
        logic [CountWidth-1:0]    rev_cnt;
        logic [MsWidth-1:0]       edge_age;
        logic [MsWidth-1:0]       pause_left;
        logic [IntervalWidth-1:0] read_age;
        drive_result_t            expected_q[$];
        int                       mismatches;
        int                       results_seen;
        int                       ticks_noted;
        int                       direction_changes;

        function new();
            regs.cut_level   = CUT_THRESHOLD_RST;
            regs.read_gap_ms = READ_INTERVAL_RST;
            regs.jam_ms      = STUCK_MS_RST;
            regs.alarm_ms    = WARNING_MS_RST;
            regs.pause_ms    = TURN_DELAY_MS_RST;
            regs.rev_steps   = STEPS_PER_REV_RST;
            running           = 1'b0;
            reversing         = 1'b0;
            unjamming         = 1'b0;
            alarm             = 1'b0;
            was_cut           = 1'b0;
            step_cnt          = '0;
            rev_cnt           = '0;
            edge_age          = '0;
            pause_left        = '0;
            read_age          = '0;
            mismatches        = 0;
            results_seen      = 0;
            ticks_noted       = 0;
            direction_changes = 0;
        endfunction

        function void set_reg(logic [CfgIndexWidth-1:0] index, logic [CfgDataWidth-1:0] value);
            case (index)
                REG_CUT_THRESHOLD:    regs.cut_level   = value[LevelWidth-1:0];
                REG_READ_INTERVAL_MS: regs.read_gap_ms = value[IntervalWidth-1:0];
                REG_STUCK_MS:         regs.jam_ms      = value[MsWidth-1:0];
                REG_WARNING_MS:       regs.alarm_ms    = value[MsWidth-1:0];
                REG_TURN_DELAY_MS:    regs.pause_ms    = value[MsWidth-1:0];
                REG_STEPS_PER_REV:    regs.rev_steps   = value[CountWidth-1:0];
                default: ;
            endcase
        endfunction

        function void finish_flip();
            reversing = !reversing;
            edge_age  = '0;
            read_age  = '0;
            direction_changes++;
        endfunction

        function void begin_flip();
            step_cnt   = '0;
            rev_cnt    = '0;
            pause_left = regs.pause_ms;
            if (pause_left == 0)
                finish_flip();
        endfunction

        function void halt(bit cut);
            edge_age = '0;
            read_age = '0;
            was_cut  = cut;
            if (running)
            begin
                running    = 1'b0;
                step_cnt   = '0;
                rev_cnt    = '0;
                reversing  = 1'b0;
                unjamming  = 1'b0;
                pause_left = '0;
            end
        endfunction

        function void run_one_ms(bit cut);
            logic [MsWidth-1:0] age;
            bit                 moved;
            age     = edge_age;
            moved   = 1'b0;
            running = 1'b1;
            if (pause_left != 0)
            begin
                pause_left--;
                if (pause_left == 0)
                    finish_flip();
                return;
            end
            if (age >= regs.alarm_ms)
            begin
                alarm = 1'b1;
                halt(cut);
                return;
            end
            if (read_age < regs.read_gap_ms)
                read_age++;
            else
            begin
                read_age = '0;
                if (age >= regs.jam_ms)
                begin
                    unjamming = 1'b1;
                    begin_flip();
                    return;
                end
                if (unjamming && reversing && rev_cnt != 0)
                begin
                    begin_flip();
                    return;
                end
                if (cut != was_cut)
                begin
                    moved = 1'b1;
                    if (!cut)
                    begin
                        step_cnt++;
                        if (step_cnt == regs.rev_steps)
                        begin
                            step_cnt = '0;
                            if (rev_cnt != REV_MAX)
                                rev_cnt++;
                            if (!reversing)
                                unjamming = 1'b0;
                        end
                    end
                    was_cut = cut;
                end
            end
            if (moved)
                edge_age = '0;
            else if (edge_age != EDGE_MAX)
                edge_age++;
        endfunction

        function void note_tick(bit run, logic [LevelWidth-1:0] level);
            drive_result_t r;
            bit            cut;
            bit            driving;
            cut = (level < regs.cut_level);
            ticks_noted++;
            if (run && !alarm)
                run_one_ms(cut);
            else
                halt(cut);
            driving            = running && !alarm && (pause_left == 0);
            r.forward_drive    = driving && !reversing;
            r.backward_drive   = driving && reversing;
            r.warning_lamp     = alarm;
            r.step_count       = step_cnt;
            r.revolution_count = rev_cnt;
            r.clearing_jam     = unjamming;
            expected_q.push_back(r);
        endfunction

        task report(string what, int got, int want);
            if (mismatches < 40)
                $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
                         what, got, want, results_seen);
            mismatches++;
        endtask

        task check_result(drive_result_t got);
            drive_result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report("result without an outstanding tick", int'(got), 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.forward_drive !== want.forward_drive)
                report("forward_drive", int'(got.forward_drive), int'(want.forward_drive));
            if (got.backward_drive !== want.backward_drive)
                report("backward_drive", int'(got.backward_drive), int'(want.backward_drive));
            if (got.warning_lamp !== want.warning_lamp)
                report("warning_lamp", int'(got.warning_lamp), int'(want.warning_lamp));
            if (got.step_count !== want.step_count)
                report("step_count", int'(got.step_count), int'(want.step_count));
            if (got.revolution_count !== want.revolution_count)
                report("revolution_count", int'(got.revolution_count),
                       int'(want.revolution_count));
            if (got.clearing_jam !== want.clearing_jam)
                report("clearing_jam", int'(got.clearing_jam), int'(want.clearing_jam));
        endtask
    endclass

endpackage : jam_check_pkg

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor jam auto-reverse testbench
// Drives millisecond tick transactions into the jam controller through its
// valid/ready channels and checks every result against the scoreboard model.
// A short directed part covers the register extremes and special cases. It is
// followed by phases of encoder motion, jams, noise and switch-off with fresh
// settings each time. The run ends with the latched warning stop.
// ----------------------------------------------------------------------------
module testbench;
    import mjar_pkg::*;
    import jam_check_pkg::*;

    localparam int HalfPeriod     = 10;
    localparam int ResetCycles    = 12;
    localparam int PhasesPerMode  = 6;
    localparam int RandomTicks    = 1530;
    localparam int LongHoldCycles = 300;
    localparam int CycleLimit     = 100000;

    localparam logic [LevelWidth-1:0] LevelMax = '1;

    typedef enum int {SEG_TURNING, SEG_JAMMED, SEG_NOISE, SEG_OFF} segment_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_data  = '0;

    int              tx_idle_pct;
    int              rx_idle_pct;
    int              settings_loaded;
    int              cycles;
    bit              long_hold_req;
    jam_settings_t   cur;
    drive_scoreboard sb;

    mjar_in_if  sample_if ();
    mjar_out_if result_if ();

    motor_jam_auto_reverse u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HalfPeriod clk = ~clk;

    task automatic send_tick(input bit run, input logic [LevelWidth-1:0] level);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            sample_if.valid <= 1'b0;
            @(negedge clk);
        end
        sample_if.valid        <= 1'b1;
        sample_if.run_request  <= run;
        sample_if.sensor_level <= level;
        do
            @(posedge clk);
        while (!sample_if.ready);
        sb.note_tick(run, level);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        sample_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] index,
                             input logic [CfgDataWidth-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_reg(index, value);
        @(negedge clk);
    endtask

    task automatic load_settings(input jam_settings_t s);
        write_reg(REG_CUT_THRESHOLD, CfgDataWidth'(s.cut_level));
        write_reg(REG_READ_INTERVAL_MS, CfgDataWidth'(s.read_gap_ms));
        write_reg(REG_STUCK_MS, CfgDataWidth'(s.jam_ms));
        write_reg(REG_WARNING_MS, CfgDataWidth'(s.alarm_ms));
        write_reg(REG_TURN_DELAY_MS, CfgDataWidth'(s.pause_ms));
        write_reg(REG_STEPS_PER_REV, CfgDataWidth'(s.rev_steps));
        cfg_we <= 1'b0;
        cur = s;
        settings_loaded++;
    endtask

    function automatic logic [LevelWidth-1:0] level_for(bit cut);
        if (cut && cur.cut_level != 0)
            return LevelWidth'($urandom_range(0, int'(cur.cut_level) - 1));
        if (!cut)
            return LevelWidth'($urandom_range(int'(cur.cut_level), int'(LevelMax)));
        return LevelWidth'($urandom_range(0, int'(LevelMax)));
    endfunction

    function automatic jam_settings_t pick_settings(int k);
        jam_settings_t s;
        s.cut_level   = LevelWidth'($urandom_range(64, 960));
        s.read_gap_ms = IntervalWidth'($urandom_range(0, 3));
        s.jam_ms      = MsWidth'($urandom_range(3, 40));
        s.alarm_ms    = EDGE_MAX;
        s.pause_ms    = MsWidth'($urandom_range(0, 6));
        s.rev_steps   = CountWidth'($urandom_range(1, 5));
        case (k % 9)
            1: s.read_gap_ms = '1;
            2: s.pause_ms = '1;
            3: s.rev_steps = '1;
            4: s.jam_ms = '1;
            5: s.cut_level = '0;
            6: s.cut_level = '1;
            7:
            begin
                s.jam_ms    = MsWidth'(1);
                s.pause_ms  = '0;
                s.rev_steps = CountWidth'(1);
            end
            8: s.rev_steps = '0;
            default: ;
        endcase
        return s;
    endfunction

    // Segments of steady encoder motion and of a blocked beam dominate, so
    // that reversals and the return to forward running are reached often.
    task automatic run_traffic(input int n_ticks);
        int                    sent;
        int                    seg_len;
        int                    half;
        int                    roll;
        bit                    phase_cut;
        bit                    run;
        logic [LevelWidth-1:0] level;
        segment_t              mode;
        sent = 0;
        while (sent < n_ticks)
        begin
            roll      = $urandom_range(0, 99);
            phase_cut = 1'($urandom_range(0, 1));
            if (cur.read_gap_ms < 8)
                half = $urandom_range(1, 3) * (int'(cur.read_gap_ms) + 1);
            else
                half = $urandom_range(1, 6);
            if (roll < 55)
            begin
                mode    = SEG_TURNING;
                seg_len = $urandom_range(8, 60);
            end
            else if (roll < 80)
            begin
                mode    = SEG_JAMMED;
                seg_len = int'(cur.jam_ms) + 2 * (int'(cur.read_gap_ms) + 1)
                          + int'(cur.pause_ms) + 4;
                if (seg_len > 150)
                    seg_len = $urandom_range(60, 150);
            end
            else if (roll < 92)
            begin
                mode    = SEG_NOISE;
                seg_len = $urandom_range(1, 10);
            end
            else
            begin
                mode    = SEG_OFF;
                seg_len = $urandom_range(1, 5);
            end
            for (int j = 0; j < seg_len && sent < n_ticks; j++)
            begin
                case (mode)
                    SEG_TURNING:
                    begin
                        if (j != 0 && j % half == 0)
                            phase_cut = !phase_cut;
                        run   = 1'b1;
                        level = level_for(phase_cut);
                    end
                    SEG_JAMMED:
                    begin
                        run   = 1'b1;
                        level = level_for(phase_cut);
                    end
                    SEG_NOISE:
                    begin
                        run   = ($urandom_range(0, 99) < 85);
                        level = LevelWidth'($urandom_range(0, int'(LevelMax)));
                    end
                    default:
                    begin
                        run   = 1'b0;
                        level = LevelWidth'($urandom_range(0, int'(LevelMax)));
                    end
                endcase
                send_tick(run, level);
                sent++;
            end
        end
    endtask

    initial
    begin : result_sink
        int            hold;
        drive_result_t got;
        hold            = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                hold          = LongHoldCycles;
                long_hold_req = 1'b0;
            end
            if (hold > 0)
            begin
                hold--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
            begin
                got.forward_drive    = result_if.forward_drive;
                got.backward_drive   = result_if.backward_drive;
                got.warning_lamp     = result_if.warning_lamp;
                got.step_count       = result_if.step_count;
                got.revolution_count = result_if.revolution_count;
                got.clearing_jam     = result_if.clearing_jam;
                sb.check_result(got);
            end
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("motor_jam_auto_reverse test failed");
        $finish;
    end

    initial
    begin : stimulus
        sample_if.valid        = 1'b0;
        sample_if.run_request  = 1'b0;
        sample_if.sensor_level = '0;
        long_hold_req          = 1'b0;
        settings_loaded        = 0;
        tx_idle_pct            = 19;
        rx_idle_pct            = 67;
        sb                     = new();
        cur                    = sb.regs;
        repeat (ResetCycles) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Register defaults straight after reset.
        send_tick(1'b0, 10'd0);
        send_tick(1'b0, 10'd1023);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b1, 10'd0);

        // A zero stuck time reverses at every evaluation.
        wait_drained();
        load_settings('{10'd512, 16'd0, 20'd0, EDGE_MAX, 20'd0, 8'd0});
        send_tick(1'b1, 10'd0);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b1, 10'd0);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b1, 10'd1023);

        // Highest threshold with one step per revolution.
        wait_drained();
        load_settings('{10'd1023, 16'd0, 20'd50, EDGE_MAX, 20'd2, 8'd1});
        send_tick(1'b1, 10'd0);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b1, 10'd0);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b1, 10'd5);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b0, 10'd0);

        // A zero threshold never sees the beam cut, so the motor jams at the first evaluation.
        wait_drained();
        load_settings('{10'd0, 16'd2, 20'd1, EDGE_MAX, 20'd3, 8'd2});
        repeat (8) send_tick(1'b1, 10'd0);

        for (int m = 0; m < 3; m++)
        begin
            case (m)
                0:
                begin
                    tx_idle_pct = 19;
                    rx_idle_pct = 67;
                end
                1:
                begin
                    tx_idle_pct = 67;
                    rx_idle_pct = 19;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int p = 0; p < PhasesPerMode; p++)
            begin
                wait_drained();
                load_settings(pick_settings(m * PhasesPerMode + p));
                if (m == 2 && p == 0)
                    long_hold_req = 1'b1;
                send_tick(1'b0, LevelWidth'($urandom_range(0, int'(LevelMax))));
                send_tick(1'b0, LevelWidth'($urandom_range(0, int'(LevelMax))));
                run_traffic(RandomTicks / (3 * PhasesPerMode));
            end
        end

        // The warning stop latches for good, so it is left to the end.
        wait_drained();
        load_settings('{10'd512, 16'd0, 20'd3, 20'd1, 20'd1, 8'd2});
        send_tick(1'b0, LevelMax);
        send_tick(1'b0, LevelMax);
        for (int j = 0; j < 24; j++)
            send_tick(1'b1, level_for(j % 2 == 0));
        repeat (6) send_tick(1'b1, LevelMax);
        repeat (30) send_tick(1'($urandom_range(0, 1)),
                              LevelWidth'($urandom_range(0, int'(LevelMax))));

        wait_drained();
        $display("Checked %0d results of %0d tick transactions under %0d register settings.",
                 sb.results_seen, sb.ticks_noted, settings_loaded);
        $display("The model saw %0d direction changes; warning lamp latched at the end: %0d.",
                 sb.direction_changes, sb.alarm);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("motor_jam_auto_reverse test passed");
        else
            $display("motor_jam_auto_reverse test failed");
        $finish;
    end

endmodule : testbench
